// ===== hdl/hmng_pkg.sv =====
// shared types, constants and helpers for the heightmap mesh normal generator
package hmng_pkg;

   localparam int VERTS_PER_CELL = 3 * 2;
   localparam int DIV_STEPS = 48;
   localparam int SQRT_STEPS = 32;

   localparam logic [15:0] NORMAL_ONE = 16'd16384;
   localparam logic [15:0] CELL_WIDTH_RESET = 16'd256;
   localparam logic [15:0] CELL_HEIGHT_RESET = 16'd256;
   localparam logic [10:0] GRID_COLUMNS_RESET = 11'd1024;
   localparam logic [15:0] GRID_ROWS_RESET = 16'd1024;

   typedef enum logic [1:0] {
      REG_CELL_WIDTH   = 2'd0,
      REG_CELL_HEIGHT  = 2'd1,
      REG_GRID_COLUMNS = 2'd2,
      REG_GRID_ROWS    = 2'd3
   } reg_index_type;

   // a = lower left, b = lower right, c = upper left, d = upper right
   typedef enum logic [1:0] {
      CORNER_A = 2'd0,
      CORNER_B = 2'd1,
      CORNER_C = 2'd2,
      CORNER_D = 2'd3
   } corner_type;

   typedef struct packed {
      logic [15:0] cell_width;
      logic [15:0] cell_height;
      logic [10:0] grid_columns;
      logic [15:0] grid_rows;
   } cfg_type;

   typedef struct packed {
      logic [31:0] za;
      logic [31:0] zb;
      logic [31:0] zc;
      logic [31:0] zd;
      logic [15:0] cj;
      logic [15:0] ci;
      logic [15:0] col_span;
      logic [15:0] row_span;
   } job_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_READ,
      F_WRITE
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_MUL,
      B_MAX,
      B_NORM,
      B_SHIFT,
      B_SQ,
      B_SQRT,
      B_DLOAD,
      B_DIV,
      B_EMIT
   } back_state_type;

   // triangles a,b,d and a,d,c
   function automatic corner_type vertex_corner(input logic [2:0] idx);
      corner_type c;
      case (idx)
         3'd0: c = CORNER_A;
         3'd1: c = CORNER_B;
         3'd2: c = CORNER_D;
         3'd3: c = CORNER_A;
         3'd4: c = CORNER_D;
         3'd5: c = CORNER_C;
         default: c = CORNER_A;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/hmng_ram.sv =====
// generic single port write, registered read ram
module hmng_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/hmng_front.sv =====
// front end: sample intake, line store, grid counters and cell job build
module hmng_front import hmng_pkg::*; #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_height_sample,
   input  cfg_type     cfg,
   output logic        push,
   output job_type     push_job,
   input  logic        full
);

   localparam int CW = $clog2(MAX_COLUMNS);

   front_state_type state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [15:0]   row_ff, row_in;
   logic [31:0]   z_ff, left_ff, upleft_ff;
   logic [31:0]   above;
   logic [15:0]   cols_eff, rows_eff;
   logic [16:0]   col_inc, row_inc;
   logic          accept, rd_en, is_cell, commit;

   always_comb begin
      if (cfg.grid_columns < 11'd2) begin
         cols_eff = 16'd2;
      end else if (16'(cfg.grid_columns) > 16'(MAX_COLUMNS)) begin
         cols_eff = 16'(MAX_COLUMNS);
      end else begin
         cols_eff = 16'(cfg.grid_columns);
      end
      rows_eff = (cfg.grid_rows < 16'd2) ? 16'd2 : cfg.grid_rows;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:  if (accept) state_in = F_READ;
         F_READ:  state_in = F_WRITE;
         F_WRITE: if (commit) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == F_IDLE);
      accept    = req_valid && req_ready;
      rd_en     = (state_ff == F_READ);
      is_cell   = (col_ff != '0) && (row_ff != 16'd0);
      commit    = (state_ff == F_WRITE) && (!is_cell || !full);
      push      = (state_ff == F_WRITE) && is_cell && !full;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      col_inc = 17'(col_ff) + 17'd1;
      row_inc = 17'(row_ff) + 17'd1;
      if (accept) begin
         // counters left beyond a new geometry restart
         if (16'(col_ff) >= cols_eff) col_in = '0;
         if (row_ff >= rows_eff) row_in = '0;
      end else if (commit) begin
         if (col_inc >= 17'(cols_eff)) begin
            col_in = '0;
            if (row_inc >= 17'(rows_eff)) begin
               row_in = '0;
            end else begin
               row_in = row_inc[15:0];
            end
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         col_ff    <= '0;
         row_ff    <= '0;
         left_ff   <= '0;
         upleft_ff <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (commit) begin
            upleft_ff <= above;
            left_ff   <= z_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         z_ff <= req_height_sample;
      end
   end

   always_comb begin
      push_job.za       = upleft_ff;
      push_job.zb       = above;
      push_job.zc       = left_ff;
      push_job.zd       = z_ff;
      push_job.cj       = 16'(col_ff) - 16'd1;
      push_job.ci       = row_ff - 16'd1;
      push_job.col_span = cols_eff - 16'd1;
      push_job.row_span = rows_eff - 16'd1;
   end

   hmng_ram #(
      .WIDTH (32),
      .DEPTH (MAX_COLUMNS)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (col_ff),
      .wr_data (z_ff),
      .rd_en   (rd_en),
      .rd_addr (col_ff),
      .rd_data (above)
   );

endmodule

// ===== hdl/hmng_fifo.sv =====
// short job queue between front end and back end
module hmng_fifo import hmng_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   job_type       mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0] count_ff;

   assign full    = (count_ff == NW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + NW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("job pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("job popped from empty queue");

endmodule

// ===== hdl/hmng_back.sv =====
// back end: corner normals, texture coordinates and vertex output register
module hmng_back import hmng_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               empty,
   input  job_type            pop_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [25:0]        rsp_pos_x,
   output logic [31:0]        rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic               rsp_last_of_cell
);

   back_state_type state_ff, state_in;
   job_type        job_ff;
   corner_type     corner_ff;
   logic [1:0]     comp_ff;
   logic           tex_phase_ff;

   logic [47:0] m_ff [3];
   logic [1:0]  neg_ff;
   logic [47:0] t_ff;
   logic [5:0]  lz_ff;
   logic [31:0] mn_ff [3];
   logic [1:0]  sq_idx_ff;
   logic [63:0] prod_ff, acc_ff;
   logic [63:0] rad_ff;
   logic [33:0] srem_ff;
   logic [31:0] root_ff;
   logic [4:0]  sit_ff;
   logic [47:0] quo_ff;
   logic [33:0] drem_ff, dv_ff;
   logic [5:0]  dcnt_ff;
   logic [15:0] nrm_ff [4][3];
   logic [16:0] tex_ff [4];
   logic [2:0]  vidx_ff;

   logic               rsp_valid_ff;
   logic [25:0]        pos_x_ff;
   logic [31:0]        pos_y_ff;
   logic [31:0]        pos_z_ff;
   logic [16:0]        tex_u_ff, tex_v_ff;
   logic [15:0]        nx_ff, ny_ff, nz_ff;
   logic               last_ff;

   logic signed [32:0] gx_top, gx_bot, gy_left, gy_right, gx, gy;
   logic [32:0]        gx_abs, gy_abs;
   logic [47:0]        mul_x, mul_y;
   logic [31:0]        mul_z;
   logic [47:0]        mx;
   logic [63:0]        sq_w, acc_sum;
   logic [35:0]        r2;
   logic [33:0]        trial;
   logic               sq_ge;
   logic [47:0]        dd;
   logic [33:0]        dv;
   logic [16:0]        tidx;
   logic [15:0]        tspan;
   logic [34:0]        rs;
   logic               d_ge;
   logic [47:0]        q_w;
   logic [15:0]        qn;
   logic               qneg;
   logic               div_last, corner_done, out_free, out_load;
   corner_type         vc;
   logic [15:0]        vcol, vrow;
   logic [31:0]        px_w, py_w;

   function automatic logic [31:0] norm_shift(input logic [47:0] m, input logic [5:0] lz);
      logic [48:0] r;
      if (lz < 6'd17) begin
         // round to nearest, ties away from zero
         r = ({1'b0, m} + (49'd1 << (6'd16 - lz))) >> (6'd17 - lz);
      end else begin
         r = {1'b0, m} << (lz - 6'd17);
      end
      return r[31:0];
   endfunction

   // edge differences of the cell
   always_comb begin
      gx_top   = $signed({job_ff.zb[31], job_ff.zb}) - $signed({job_ff.za[31], job_ff.za});
      gx_bot   = $signed({job_ff.zd[31], job_ff.zd}) - $signed({job_ff.zc[31], job_ff.zc});
      gy_left  = $signed({job_ff.zc[31], job_ff.zc}) - $signed({job_ff.za[31], job_ff.za});
      gy_right = $signed({job_ff.zd[31], job_ff.zd}) - $signed({job_ff.zb[31], job_ff.zb});
      gx       = corner_ff[1] ? gx_bot : gx_top;
      gy       = corner_ff[0] ? gy_right : gy_left;
      gx_abs   = gx[32] ? 33'(-gx) : 33'(gx);
      gy_abs   = gy[32] ? 33'(-gy) : 33'(gy);
      mul_x    = 48'(gx_abs) * 48'(cfg.cell_height);
      mul_y    = 48'(gy_abs) * 48'(cfg.cell_width);
      mul_z    = 32'(cfg.cell_width) * 32'(cfg.cell_height);
   end

   always_comb begin
      mx = m_ff[0];
      if (m_ff[1] > mx) mx = m_ff[1];
      if (m_ff[2] > mx) mx = m_ff[2];
      sq_w    = 64'(mn_ff[0]) * 64'(mn_ff[0]);
      acc_sum = acc_ff + prod_ff;
      r2      = {srem_ff, rad_ff[63:62]};
      trial   = {root_ff, 2'b01};
      sq_ge   = (r2 >= 36'(trial));
   end

   // divider operands: normal component or texture coordinate
   always_comb begin
      case (comp_ff)
         2'd0:    tidx = 17'(job_ff.cj);
         2'd1:    tidx = 17'(job_ff.cj) + 17'd1;
         2'd2:    tidx = 17'(job_ff.ci);
         default: tidx = 17'(job_ff.ci) + 17'd1;
      endcase
      tspan = comp_ff[1] ? job_ff.row_span : job_ff.col_span;
      if (tex_phase_ff) begin
         dd = 48'({tidx, 17'b0}) + 48'(tspan);
         dv = 34'({tspan, 1'b0});
      end else begin
         dd = 48'({mn_ff[0], 15'b0}) + 48'(root_ff);
         dv = 34'({root_ff, 1'b0});
      end
      rs   = {drem_ff, quo_ff[47]};
      d_ge = (rs >= 35'(dv_ff));
      q_w  = {quo_ff[46:0], d_ge};
      qn   = q_w[15:0];
      case (comp_ff)
         2'd0:    qneg = neg_ff[0];
         2'd1:    qneg = neg_ff[1];
         default: qneg = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (!empty) state_in = B_MUL;
         B_MUL:   state_in = B_MAX;
         B_MAX: begin
            if (mx == '0) begin
               state_in = (corner_ff == CORNER_D) ? B_DLOAD : B_MUL;
            end else begin
               state_in = B_NORM;
            end
         end
         B_NORM:  if (t_ff[47]) state_in = B_SHIFT;
         B_SHIFT: state_in = B_SQ;
         B_SQ:    if (sq_idx_ff == 2'd3) state_in = B_SQRT;
         B_SQRT:  if (sit_ff == 5'(SQRT_STEPS - 1)) state_in = B_DLOAD;
         B_DLOAD: state_in = B_DIV;
         B_DIV: begin
            if (div_last) begin
               if (tex_phase_ff) begin
                  state_in = (comp_ff == 2'd3) ? B_EMIT : B_DLOAD;
               end else if (comp_ff == 2'd2) begin
                  state_in = (corner_ff == CORNER_D) ? B_DLOAD : B_MUL;
               end else begin
                  state_in = B_DLOAD;
               end
            end
         end
         B_EMIT:  if (out_load && vidx_ff == 3'(VERTS_PER_CELL - 1)) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop         = (state_ff == B_IDLE) && !empty;
      div_last    = (state_ff == B_DIV) && (dcnt_ff == 6'(DIV_STEPS - 1));
      corner_done = ((state_ff == B_MAX) && (mx == '0)) ||
                    (div_last && !tex_phase_ff && comp_ff == 2'd2);
      out_free    = !rsp_valid_ff || rsp_ready;
      out_load    = (state_ff == B_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // sequencing counters
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff       <= pop_job;
         corner_ff    <= CORNER_A;
         comp_ff      <= 2'd0;
         tex_phase_ff <= 1'b0;
         vidx_ff      <= 3'd0;
      end
      if (corner_done) begin
         comp_ff <= 2'd0;
         if (corner_ff == CORNER_D) begin
            tex_phase_ff <= 1'b1;
         end else begin
            corner_ff <= corner_type'(corner_ff + 2'd1);
         end
      end else if (div_last) begin
         comp_ff <= comp_ff + 2'd1;
      end
      if (out_load) begin
         vidx_ff <= vidx_ff + 3'd1;
      end
   end

   // normal datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         B_MUL: begin
            m_ff[0]   <= mul_x;
            m_ff[1]   <= mul_y;
            m_ff[2]   <= {8'b0, mul_z, 8'b0};
            neg_ff[0] <= !gx[32] && (gx != '0);
            neg_ff[1] <= !gy[32] && (gy != '0);
         end
         B_MAX: begin
            t_ff  <= mx;
            lz_ff <= 6'd0;
            if (mx == '0) begin
               // flat terrain with a zero cell size
               nrm_ff[corner_ff][0] <= 16'd0;
               nrm_ff[corner_ff][1] <= 16'd0;
               nrm_ff[corner_ff][2] <= NORMAL_ONE;
            end
         end
         B_NORM: begin
            if (!t_ff[47]) begin
               t_ff  <= t_ff << 1;
               lz_ff <= lz_ff + 6'd1;
            end
         end
         B_SHIFT: begin
            mn_ff[0]  <= norm_shift(m_ff[0], lz_ff);
            mn_ff[1]  <= norm_shift(m_ff[1], lz_ff);
            mn_ff[2]  <= norm_shift(m_ff[2], lz_ff);
            acc_ff    <= '0;
            sq_idx_ff <= 2'd0;
         end
         B_SQ: begin
            sq_idx_ff <= sq_idx_ff + 2'd1;
            if (sq_idx_ff != 2'd3) begin
               // rotate so the squared component is always in slot zero
               prod_ff  <= sq_w;
               mn_ff[0] <= mn_ff[1];
               mn_ff[1] <= mn_ff[2];
               mn_ff[2] <= mn_ff[0];
            end
            if (sq_idx_ff != 2'd0) begin
               acc_ff <= acc_sum;
            end
            if (sq_idx_ff == 2'd3) begin
               rad_ff  <= acc_sum;
               srem_ff <= '0;
               root_ff <= '0;
               sit_ff  <= '0;
            end
         end
         B_SQRT: begin
            rad_ff  <= rad_ff << 2;
            srem_ff <= sq_ge ? 34'(r2 - 36'(trial)) : 34'(r2);
            root_ff <= {root_ff[30:0], sq_ge};
            sit_ff  <= sit_ff + 5'd1;
         end
         B_DLOAD: begin
            quo_ff  <= dd;
            dv_ff   <= dv;
            drem_ff <= '0;
            dcnt_ff <= '0;
         end
         B_DIV: begin
            quo_ff  <= q_w;
            drem_ff <= d_ge ? 34'(rs - 35'(dv_ff)) : 34'(rs);
            dcnt_ff <= dcnt_ff + 6'd1;
            if (div_last) begin
               if (tex_phase_ff) begin
                  tex_ff[comp_ff] <= q_w[16:0];
               end else begin
                  nrm_ff[corner_ff][comp_ff] <= qneg ? 16'(-qn) : qn;
                  mn_ff[0] <= mn_ff[1];
                  mn_ff[1] <= mn_ff[2];
                  mn_ff[2] <= mn_ff[0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   // vertex assembly
   always_comb begin
      vc   = vertex_corner(vidx_ff);
      vcol = job_ff.cj + {15'b0, vc[0]};
      vrow = job_ff.ci + {15'b0, vc[1]};
      px_w = 32'(cfg.cell_width) * 32'(vcol);
      py_w = 32'(cfg.cell_height) * 32'(vrow);
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         pos_x_ff <= px_w[25:0];
         pos_y_ff <= py_w;
         case (vc)
            CORNER_A: pos_z_ff <= job_ff.za;
            CORNER_B: pos_z_ff <= job_ff.zb;
            CORNER_C: pos_z_ff <= job_ff.zc;
            default:  pos_z_ff <= job_ff.zd;
         endcase
         tex_u_ff <= tex_ff[{1'b0, vc[0]}];
         tex_v_ff <= tex_ff[{1'b1, vc[1]}];
         nx_ff    <= nrm_ff[vc][0];
         ny_ff    <= nrm_ff[vc][1];
         nz_ff    <= nrm_ff[vc][2];
         last_ff  <= (vidx_ff == 3'(VERTS_PER_CELL - 1));
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_pos_z        = pos_z_ff;
   assign rsp_tex_u        = tex_u_ff;
   assign rsp_tex_v        = tex_v_ff;
   assign rsp_normal_x     = nx_ff;
   assign rsp_normal_y     = ny_ff;
   assign rsp_normal_z     = nz_ff;
   assign rsp_last_of_cell = last_ff;

   a_nz_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !rsp_normal_z[15])
      else $error("normal z negative");
   a_nx_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_normal_x <= 16'sd16384 && rsp_normal_x >= -16'sd16384))
      else $error("normal x outside unit range");

endmodule

// ===== hdl/heightmap_mesh_normal_generator.sv =====
// top level: register port, front end, job queue and back end
//
//  channel  | handshake           | payload
//  req      | req_valid/req_ready | req_height_sample
//  rsp      | rsp_valid/rsp_ready | pos, tex, normal, last_of_cell
//  csr      | psel/penable/pwrite | paddr, pwdata, prdata
//
// front end handles one sample at a time: accept, line store read, write back
// back end works on one cell at a time: per corner up to 47 normalize steps,
// 32 square root steps and three 48 step divisions, then four texture divisions;
// a flat cell with a zero cell size skips the corner math
// samples that close no cell pass through the front end only
// synchronous reset clears counters and handshakes; the line store needs no clearing
// a two entry job queue lets the front end keep taking samples while the back end works
module heightmap_mesh_normal_generator import hmng_pkg::*; #(
   parameter int MAX_COLUMNS = 1024,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_height_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [25:0]        rsp_pos_x,
   output logic [31:0]        rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic               rsp_last_of_cell,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   cfg_type cfg_ff;
   logic    push, pop, full, empty;
   job_type push_job, pop_job;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_width   <= CELL_WIDTH_RESET;
         cfg_ff.cell_height  <= CELL_HEIGHT_RESET;
         cfg_ff.grid_columns <= GRID_COLUMNS_RESET;
         cfg_ff.grid_rows    <= GRID_ROWS_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (reg_index_type'(paddr[3:2]))
            REG_CELL_WIDTH:   cfg_ff.cell_width   <= pwdata[15:0];
            REG_CELL_HEIGHT:  cfg_ff.cell_height  <= pwdata[15:0];
            REG_GRID_COLUMNS: cfg_ff.grid_columns <= pwdata[10:0];
            REG_GRID_ROWS:    cfg_ff.grid_rows    <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[3:2]))
         REG_CELL_WIDTH:   prdata = 32'(cfg_ff.cell_width);
         REG_CELL_HEIGHT:  prdata = 32'(cfg_ff.cell_height);
         REG_GRID_COLUMNS: prdata = 32'(cfg_ff.grid_columns);
         REG_GRID_ROWS:    prdata = 32'(cfg_ff.grid_rows);
         default:          prdata = '0;
      endcase
   end

   hmng_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_height_sample (req_height_sample),
      .cfg               (cfg_ff),
      .push              (push),
      .push_job          (push_job),
      .full              (full)
   );

   hmng_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   hmng_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .empty            (empty),
      .pop_job          (pop_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_last_of_cell (rsp_last_of_cell)
   );

endmodule

// ===== test/mesh_vertex_checker.sv =====
// vertex checker: predicts mesh vertices from accepted samples and compares them
`timescale 1ns / 1ps
module mesh_vertex_checker import hmng_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [31:0]        req_height_sample,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [25:0]        rsp_pos_x,
   input  logic [31:0]        rsp_pos_y,
   input  logic signed [31:0] rsp_pos_z,
   input  logic [16:0]        rsp_tex_u,
   input  logic [16:0]        rsp_tex_v,
   input  logic signed [15:0] rsp_normal_x,
   input  logic signed [15:0] rsp_normal_y,
   input  logic signed [15:0] rsp_normal_z,
   input  logic               rsp_last_of_cell,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int                 fail_count,
   output int                 vertices_pending
);

   localparam int LINE_DEPTH = 1024;

   typedef struct {
      logic [25:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
      logic [15:0] normal_x;
      logic [15:0] normal_y;
      logic [15:0] normal_z;
      logic        last;
   } vertex_type;

   vertex_type  vertex_queue[$];
   logic [31:0] line_buf[LINE_DEPTH];
   logic [31:0] left_z, upper_left_z;
   int unsigned col_count, row_count;
   cfg_type     cfg;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bit_val;
      res = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val >>= 2;
      while (bit_val != 0) begin
         if (v >= res + bit_val) begin
            v -= res + bit_val;
            res = (res >> 1) + bit_val;
         end else begin
            res >>= 1;
         end
         bit_val >>= 2;
      end
      return res;
   endfunction

   function automatic void corner_normal(input longint gx, input longint gy,
                                         input longint unsigned dx, input longint unsigned dy,
                                         output logic [15:0] n[3]);
      longint unsigned m[3];
      longint unsigned mx, sum, len, q;
      logic neg[3];
      int b, s;
      neg[0] = gx > 0;
      m[0] = longint'(gx < 0 ? -gx : gx) * dy;
      neg[1] = gy > 0;
      m[1] = longint'(gy < 0 ? -gy : gy) * dx;
      neg[2] = 1'b0;
      m[2] = (dx * dy) << 8;
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      if (mx == 0) begin
         n[0] = 0;
         n[1] = 0;
         n[2] = NORMAL_ONE;
         return;
      end
      b = 0;
      while (mx != 0) begin
         b++;
         mx >>= 1;
      end
      for (int k = 0; k < 3; k++) begin
         if (b > 31) begin
            s = b - 31;
            m[k] = (m[k] + (64'd1 << (s - 1))) >> s;
         end else if (b < 31) begin
            m[k] <<= (31 - b);
         end
      end
      sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = int_sqrt(sum);
      for (int k = 0; k < 3; k++) begin
         q = ((m[k] << 15) + len) / (len << 1);
         n[k] = neg[k] ? 16'(-q) : 16'(q);
      end
   endfunction

   function automatic logic [16:0] tex_coord(input int unsigned idx, input int unsigned span);
      longint unsigned d;
      d = span;
      return 17'(((longint'(idx) << 17) + d) / (d << 1));
   endfunction

   function automatic vertex_type make_vertex(input int unsigned col, input int unsigned row,
                                              input logic [31:0] z, input int unsigned cols,
                                              input int unsigned rows, input logic [15:0] n[3],
                                              input logic last);
      vertex_type v;
      v.pos_x = 26'(longint'(cfg.cell_width) * col);
      v.pos_y = 32'(longint'(cfg.cell_height) * row);
      v.pos_z = z;
      v.tex_u = tex_coord(col, cols - 1);
      v.tex_v = tex_coord(row, rows - 1);
      v.normal_x = n[0];
      v.normal_y = n[1];
      v.normal_z = n[2];
      v.last = last;
      return v;
   endfunction

   task automatic predict_cell(input logic [31:0] z);
      int unsigned cols, rows, cj, ci;
      logic [31:0] above;
      longint sa, sb, sc, sd;
      longint unsigned dx, dy;
      logic [15:0] na[3], nb[3], nc[3], nd[3];
      cols = cfg.grid_columns;
      rows = cfg.grid_rows;
      if (cols < 2) cols = 2;
      if (cols > LINE_DEPTH) cols = LINE_DEPTH;
      if (rows < 2) rows = 2;
      if (col_count >= cols) col_count = 0;
      if (row_count >= rows) row_count = 0;
      above = line_buf[col_count];
      if (row_count >= 1 && col_count >= 1) begin
         dx = cfg.cell_width;
         dy = cfg.cell_height;
         sa = longint'($signed(upper_left_z));
         sb = longint'($signed(above));
         sc = longint'($signed(left_z));
         sd = longint'($signed(z));
         corner_normal(sb - sa, sc - sa, dx, dy, na);
         corner_normal(sb - sa, sd - sb, dx, dy, nb);
         corner_normal(sd - sc, sc - sa, dx, dy, nc);
         corner_normal(sd - sc, sd - sb, dx, dy, nd);
         cj = col_count - 1;
         ci = row_count - 1;
         vertex_queue.push_back(make_vertex(cj, ci, upper_left_z, cols, rows, na, 0));
         vertex_queue.push_back(make_vertex(cj + 1, ci, above, cols, rows, nb, 0));
         vertex_queue.push_back(make_vertex(cj + 1, ci + 1, z, cols, rows, nd, 0));
         vertex_queue.push_back(make_vertex(cj, ci, upper_left_z, cols, rows, na, 0));
         vertex_queue.push_back(make_vertex(cj + 1, ci + 1, z, cols, rows, nd, 0));
         vertex_queue.push_back(make_vertex(cj, ci + 1, left_z, cols, rows, nc, 1));
      end
      upper_left_z = above;
      left_z = z;
      line_buf[col_count] = z;
      col_count++;
      if (col_count >= cols) begin
         col_count = 0;
         row_count++;
         if (row_count >= rows) row_count = 0;
      end
   endtask

   task automatic compare_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      vertex_type e;
      if (reset) begin
         vertex_queue.delete();
         fail_count = 0;
         left_z = 0;
         upper_left_z = 0;
         col_count = 0;
         row_count = 0;
         cfg.cell_width = CELL_WIDTH_RESET;
         cfg.cell_height = CELL_HEIGHT_RESET;
         cfg.grid_columns = GRID_COLUMNS_RESET;
         cfg.grid_rows = GRID_ROWS_RESET;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[3:2]))
               REG_CELL_WIDTH:   cfg.cell_width = pwdata[15:0];
               REG_CELL_HEIGHT:  cfg.cell_height = pwdata[15:0];
               REG_GRID_COLUMNS: cfg.grid_columns = pwdata[10:0];
               REG_GRID_ROWS:    cfg.grid_rows = pwdata[15:0];
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (vertex_queue.size() == 0) begin
               $error("vertex transfer with no vertex expected");
               fail_count++;
            end else begin
               e = vertex_queue.pop_front();
               compare_field("pos_x", e.pos_x, rsp_pos_x);
               compare_field("pos_y", e.pos_y, rsp_pos_y);
               compare_field("pos_z", e.pos_z, $unsigned(rsp_pos_z));
               compare_field("tex_u", e.tex_u, rsp_tex_u);
               compare_field("tex_v", e.tex_v, rsp_tex_v);
               compare_field("normal_x", e.normal_x, $unsigned(rsp_normal_x));
               compare_field("normal_y", e.normal_y, $unsigned(rsp_normal_y));
               compare_field("normal_z", e.normal_z, $unsigned(rsp_normal_z));
               compare_field("last_of_cell", e.last, rsp_last_of_cell);
            end
         end
         if (req_valid && req_ready) predict_cell(req_height_sample);
      end
      vertices_pending = vertex_queue.size();
   end

endmodule

// ===== test/tb_top.sv =====
// testbench top: drives samples, register writes and vertex back-pressure
`timescale 1ns / 1ps
module tb_top;
   import hmng_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_SAMPLES = 130;

   logic               clock, reset;
   logic               req_valid, req_ready;
   logic [31:0]        req_height_sample;
   logic               rsp_valid, rsp_ready;
   logic [25:0]        rsp_pos_x;
   logic [31:0]        rsp_pos_y;
   logic signed [31:0] rsp_pos_z;
   logic [16:0]        rsp_tex_u, rsp_tex_v;
   logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic               rsp_last_of_cell;
   logic               psel, penable, pwrite, pready;
   logic [3:0]         paddr;
   logic [31:0]        pwdata, prdata;

   int fail_count, vertices_pending, cycle_count, samples_sent;
   bit quiet, hold_go;
   // mirror of the block's geometry and position in the frame
   int unsigned geo_cols, geo_rows, at_col, at_row;

   heightmap_mesh_normal_generator DUT (.*);

   mesh_vertex_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // vertex sink with random stalls and one long hold-off
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1;
            hold_left = 6000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 23);
         end
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_GRID_COLUMNS: geo_cols = value[10:0];
         REG_GRID_ROWS:    geo_rows = value[15:0];
         default: ;
      endcase
   endtask

   task automatic send_sample(input logic [31:0] z);
      int unsigned cols, rows;
      if (!quiet && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 23);
      end
      req_valid <= 1'b1;
      req_height_sample <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
      cols = geo_cols < 2 ? 2 : (geo_cols > 1024 ? 1024 : geo_cols);
      rows = geo_rows < 2 ? 2 : geo_rows;
      if (at_col >= cols) at_col = 0;
      if (at_row >= rows) at_row = 0;
      at_col++;
      if (at_col >= cols) begin
         at_col = 0;
         at_row++;
         if (at_row >= rows) at_row = 0;
      end
   endtask

   // block idle: nothing expected and the front end done with its last sample
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (vertices_pending != 0);
      repeat (16) @(posedge clock);
   endtask

   function automatic logic [31:0] random_height(input logic [31:0] base);
      case ($urandom_range(3))
         0: return $urandom;
         1: return base + 32'($signed($urandom_range(2000)) - 1000);
         2: return base + ($urandom & 32'h001F_FFFF) - 32'h0010_0000;
         default: return base;
      endcase
   endfunction

   task automatic finish_frame();
      while (at_col != 0 || at_row != 0) send_sample($urandom);
   endtask

   initial begin
      logic [31:0] base;
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_height_sample = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      quiet = 0;
      hold_go = 0;
      samples_sent = 0;
      geo_cols = GRID_COLUMNS_RESET;
      geo_rows = GRID_ROWS_RESET;
      at_col = 0;
      at_row = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // shrink columns mid row so the column counter restarts
      send_sample(32'h0001_0000);
      send_sample(32'hFFFF_0000);
      wait_idle();
      csr_write(REG_GRID_COLUMNS, 32'd1);
      csr_write(REG_GRID_ROWS, 32'd0);
      at_col = 0;
      // extreme heights on a single cell
      send_sample(32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      finish_frame();
      // zero cell width with flat terrain gives the straight-up normal
      wait_idle();
      csr_write(REG_CELL_WIDTH, 32'd0);
      repeat (4) send_sample(32'h0003_0000);
      wait_idle();
      csr_write(REG_CELL_WIDTH, 32'hFFFF);
      csr_write(REG_CELL_HEIGHT, 32'hFFFF);
      send_sample(32'h0000_0000);
      send_sample(32'h0000_0001);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h4000_0000);
      // oversized geometry, then shrink back mid row
      wait_idle();
      csr_write(REG_GRID_COLUMNS, 32'd2047);
      csr_write(REG_GRID_ROWS, 32'd65535);
      repeat (4) send_sample($urandom);
      wait_idle();
      csr_write(REG_GRID_COLUMNS, 32'd3);
      csr_write(REG_GRID_ROWS, 32'd2);
      if (at_col >= 3) at_col = 0;
      if (at_row >= 2) at_row = 0;
      finish_frame();

      phase = 0;
      samples_sent = 0;
      while (samples_sent < RANDOM_SAMPLES) begin
         wait_idle();
         csr_write(REG_GRID_COLUMNS, $urandom_range(6, 2));
         csr_write(REG_GRID_ROWS, $urandom_range(5, 2));
         // enough cells during the hold-off to fill the job queue
         if (phase == 1) begin
            csr_write(REG_GRID_COLUMNS, 32'd6);
            csr_write(REG_GRID_ROWS, 32'd5);
         end
         case ($urandom_range(4))
            0: csr_write(REG_CELL_WIDTH, 32'd1);
            1: csr_write(REG_CELL_WIDTH, 32'hFFFF);
            default: csr_write(REG_CELL_WIDTH, $urandom_range(65535, 1));
         endcase
         case ($urandom_range(4))
            0: csr_write(REG_CELL_HEIGHT, 32'd1);
            1: csr_write(REG_CELL_HEIGHT, 32'hFFFF);
            default: csr_write(REG_CELL_HEIGHT, $urandom_range(65535, 1));
         endcase
         quiet = (phase == 3 || phase == 4);
         if (phase == 1) hold_go = 1;
         base = $urandom;
         do send_sample(random_height(base)); while (at_col != 0 || at_row != 0);
         phase++;
      end
      quiet = 0;
      req_valid <= 1'b0;
      do @(posedge clock); while (vertices_pending != 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
